@@ src/bia_pkg.sv @@
`timescale 1ns / 1ps
// bia_pkg: constants, payload structs, codes and the find-first-clear helper
// for the bitmap id allocator. depends on nothing.
package bia_pkg;

	localparam int NUM_IDS   = 4096;
	localparam int WORD_BITS = 32;
	localparam int NUM_WORDS = NUM_IDS / WORD_BITS;
	localparam int ID_W      = 12;
	localparam int CNT_W     = 13;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int WADDR_W   = $clog2(NUM_WORDS);

	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_RELEASED  = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_USED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CHECK
	} state_t;

	typedef struct packed {
		logic            action;
		logic [ID_W-1:0] id_index;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]  result_id;
		status_t          status;
		logic [CNT_W-1:0] ids_in_use;
	} rsp_t;

	// lowest clear bit of a word; only meaningful when some bit is clear
	function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

@@ src/bia_req_if.sv @@
`timescale 1ns / 1ps
// bia_req_if: request channel (valid/ready plus request payload).
// depends on bia_pkg.
interface bia_req_if;
	logic          valid;
	logic          ready;
	bia_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/bia_rsp_if.sv @@
`timescale 1ns / 1ps
// bia_rsp_if: response channel (valid/ready plus response payload).
// depends on bia_pkg.
interface bia_rsp_if;
	logic          valid;
	logic          ready;
	bia_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/bitmap_id_allocator.sv @@
`timescale 1ns / 1ps
// bitmap_id_allocator: next-fit id allocator over 4096 ids.
// depends on bia_pkg, bia_req_if, bia_rsp_if and bia_ram.
//
// usage: a beat on req asks to allocate (action 0) or to release id_index
// (action 1). every request gives exactly one beat on rsp with the new id
// (allocate), the status and the count of ids in use afterwards.
// the used map lives in a 128 x 32 ram behind one read/check/write loop.
// steps from request to response register:
//   allocate with free ids: a read step then a check step for each word scanned
//     (1 to 129 words), with the one ram read port and the single find-first-clear unit
//   allocate when all ids are used: response registered on accept, no ram access
//   release: one read-modify-write (a read step then a check step)
// next-fit usually finds a free bit in the first word. the block takes one
// request at a time: req.ready is high only when idle and the response
// register is empty.
// reset: all ids free, search pointer and count zero; per-word valid flags
// make the ram read as zero until written, so no clearing pass is needed.
// when rsp is stalled the response holds and no new request is taken.
module bitmap_id_allocator (
	input  logic          clk,
	input  logic          arst_n,
	bia_req_if.sink       req,
	bia_rsp_if.source     rsp
);

	bia_pkg::state_t                    state_q, state_d;
	logic [bia_pkg::WADDR_W-1:0]        word_q;
	logic [bia_pkg::BIT_W-1:0]          bit_q;
	logic                               first_q;
	logic                               rel_q;
	logic [bia_pkg::ID_W-1:0]           ptr_q;
	logic [bia_pkg::CNT_W-1:0]          cnt_q;
	logic [bia_pkg::NUM_WORDS-1:0]      vld_q;
	bia_pkg::rsp_t                      rsp_q;
	logic                               rsp_valid_q;

	logic                               accept;
	logic                               full;
	logic                               rd_en;
	logic                               wr_en;
	logic [bia_pkg::WORD_BITS-1:0]      rd_data;
	logic [bia_pkg::WORD_BITS-1:0]      wr_data;
	logic [bia_pkg::WORD_BITS-1:0]      word_data;
	logic [bia_pkg::WORD_BITS-1:0]      low_mask;
	logic [bia_pkg::WORD_BITS-1:0]      scan;
	logic                               hit;
	logic [bia_pkg::BIT_W-1:0]          pos;
	logic                               bit_set;
	logic                               done;
	logic [bia_pkg::ID_W-1:0]           new_id;

	assign req.ready = (state_q == bia_pkg::S_IDLE) && !rsp_valid_q;
	assign accept    = req.valid && req.ready;
	assign full      = cnt_q == bia_pkg::CNT_W'(bia_pkg::NUM_IDS);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	bia_ram #(
		.WIDTH (bia_pkg::WORD_BITS),
		.DEPTH (bia_pkg::NUM_WORDS)
	) u_map (
		.clk   (clk),
		.we    (wr_en),
		.waddr (word_q),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (word_q),
		.rdata (rd_data)
	);

	// words never written read as all free
	assign word_data = vld_q[word_q] ? rd_data : '0;
	// on the first word, bits below the pointer count as taken
	assign low_mask  = first_q ? ~({bia_pkg::WORD_BITS{1'b1}} << ptr_q[bia_pkg::BIT_W-1:0])
	                           : '0;
	assign scan      = word_data | low_mask;
	assign hit       = ~&scan;
	assign pos       = bia_pkg::first_zero(scan);
	assign bit_set   = word_data[bit_q];
	assign done      = rel_q || hit;
	assign new_id    = {word_q, pos};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bia_pkg::S_IDLE: begin
				if (accept && !(req.data.action == bia_pkg::ACT_ALLOC && full)) begin
					state_d = bia_pkg::S_READ;
				end
			end
			bia_pkg::S_READ: begin
				state_d = bia_pkg::S_CHECK;
			end
			bia_pkg::S_CHECK: begin
				state_d = done ? bia_pkg::S_IDLE : bia_pkg::S_READ;
			end
			default: begin
				state_d = bia_pkg::S_IDLE;
			end
		endcase
	end

	// ram controls
	always_comb begin
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_data = word_data;
		unique case (state_q)
			bia_pkg::S_READ: begin
				rd_en = 1'b1;
			end
			bia_pkg::S_CHECK: begin
				if (rel_q) begin
					wr_en   = bit_set;
					wr_data = word_data & ~(bia_pkg::WORD_BITS'(1) << bit_q);
				end else begin
					wr_en   = hit;
					wr_data = word_data | (bia_pkg::WORD_BITS'(1) << pos);
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bia_pkg::S_IDLE;
			ptr_q       <= '0;
			cnt_q       <= '0;
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
			first_q     <= 1'b0;
			rel_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (wr_en) begin
				vld_q[word_q] <= 1'b1;
			end
			if (accept) begin
				rel_q   <= req.data.action == bia_pkg::ACT_RELEASE;
				first_q <= req.data.action == bia_pkg::ACT_ALLOC;
				if (req.data.action == bia_pkg::ACT_ALLOC && full) begin
					rsp_valid_q <= 1'b1;
				end
			end
			if (state_q == bia_pkg::S_CHECK) begin
				first_q <= 1'b0;
				if (done) begin
					rsp_valid_q <= 1'b1;
				end
				if (!rel_q && hit) begin
					ptr_q <= new_id + 1'b1;
					cnt_q <= cnt_q + 1'b1;
				end else if (rel_q && bit_set) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			bit_q <= req.data.id_index[bia_pkg::BIT_W-1:0];
			if (req.data.action == bia_pkg::ACT_RELEASE) begin
				word_q <= req.data.id_index[bia_pkg::ID_W-1:bia_pkg::BIT_W];
			end else begin
				word_q <= ptr_q[bia_pkg::ID_W-1:bia_pkg::BIT_W];
			end
			if (req.data.action == bia_pkg::ACT_ALLOC && full) begin
				rsp_q.result_id  <= '0;
				rsp_q.status     <= bia_pkg::ST_FULL;
				rsp_q.ids_in_use <= cnt_q;
			end
		end
		if (state_q == bia_pkg::S_CHECK) begin
			if (!done) begin
				word_q <= word_q + 1'b1;
			end
			if (rel_q) begin
				rsp_q.result_id  <= '0;
				rsp_q.status     <= bit_set ? bia_pkg::ST_RELEASED : bia_pkg::ST_NOT_USED;
				rsp_q.ids_in_use <= bit_set ? cnt_q - 1'b1 : cnt_q;
			end else if (hit) begin
				rsp_q.result_id  <= new_id;
				rsp_q.status     <= bia_pkg::ST_ALLOCATED;
				rsp_q.ids_in_use <= cnt_q + 1'b1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= bia_pkg::CNT_W'(bia_pkg::NUM_IDS))
		else $error("id count above capacity");

	a_write_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == bia_pkg::S_CHECK)
		else $error("map written outside the check step");

	a_no_zero_release: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bia_pkg::S_CHECK && rel_q && bit_set) |-> cnt_q != '0)
		else $error("release of a used id with zero count");

	a_result_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != bia_pkg::ST_ALLOCATED) |-> rsp_q.result_id == '0)
		else $error("nonzero id on a non-allocate response");

	a_alloc_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bia_pkg::S_CHECK && !rel_q && hit) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("allocation did not bump the count");

endmodule

@@ src/bia_ram.sv @@
`timescale 1ns / 1ps
// bia_ram: generic single-write, single-read ram with registered read data.
// depends on nothing.
module bia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
